/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is asserted
`define FCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/fcs_pkg.sv */
package fcs_pkg;

  // default sizes
  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 40;

  // fixed field widths
  localparam int TAP_COUNT_W = 6;
  localparam int TAP_INDEX_W = 5;

  // opcodes
  localparam logic OP_KERNEL_WRITE = 1'b0;
  localparam logic OP_SAMPLE_PUSH  = 1'b1;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic hist_clear;
    logic hist_inject;
    logic hist_shift;
    logic kern_write;
    logic kern_shift;
  } fcs_cell_ctrl_t;

endpackage

/* hdl/fcs_cell.sv */
module fcs_cell #(
  parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 5,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcs_pkg::fcs_cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0]              align_i,
  input  logic [IDX_W-1:0]              widx_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] kdata_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_prev_i,
  input  logic signed [SAMPLE_BITS-1:0] kern_prev_i,
  output logic signed [SAMPLE_BITS-1:0] hist_o,
  output logic signed [SAMPLE_BITS-1:0] kern_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [SAMPLE_BITS-1:0] hist_r, hist_nxt;
  logic signed [SAMPLE_BITS-1:0] kern_r, kern_nxt;

  // history slot: clear, new sample at the insert point, neighbor on inject or shift, else hold
  always_comb begin
    priority if (ctrl_i.hist_clear) begin
      hist_nxt = '0;
    end else if (ctrl_i.hist_inject && (align_i == MY_IDX)) begin
      hist_nxt = sample_i;
    end else if (ctrl_i.hist_inject || ctrl_i.hist_shift) begin
      hist_nxt = hist_prev_i;
    end else begin
      hist_nxt = hist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  // kernel slot: addressed write or ring rotation, else hold
  always_comb begin
    priority if (ctrl_i.kern_write && (widx_i == MY_IDX)) begin
      kern_nxt = kdata_i;
    end else if (ctrl_i.kern_shift) begin
      kern_nxt = kern_prev_i;
    end else begin
      kern_nxt = kern_r;
    end
  end

  always_ff @(posedge clk) begin
    kern_r <= kern_nxt;
  end

  assign hist_o = hist_r;
  assign kern_o = kern_r;

endmodule

/* hdl/fcs_mac.sv */
module fcs_mac #(
  parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = fcs_pkg::ACC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          start_i,
  input  logic                          step_i,
  input  logic                          use_tap_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_i,
  input  logic signed [SAMPLE_BITS-1:0] kern_i,
  output logic signed [ACC_BITS-1:0]    total_o
);

  logic signed [2*SAMPLE_BITS-1:0] prod_full;
  logic signed [ACC_BITS-1:0]      prod_r, prod_nxt;
  logic signed [ACC_BITS-1:0]      acc_r, acc_nxt;

  assign prod_full = hist_i * kern_i;

  // registered product, zero for taps outside the window
  always_comb begin
    priority if (start_i) begin
      prod_nxt = '0;
    end else if (step_i) begin
      prod_nxt = use_tap_i ? ACC_BITS'(prod_full) : '0;
    end else begin
      prod_nxt = prod_r;
    end
  end

  // running sum, wraps at the accumulator width
  always_comb begin
    priority if (start_i) begin
      acc_nxt = '0;
    end else if (step_i) begin
      acc_nxt = acc_r + prod_r;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign total_o = acc_r + prod_r;

endmodule

/* hdl/full_correlation_stream_unit.sv */
// channel  direction  handshake           payload
// cfg      in         cfg_wr_en           cfg_wr_data (tap count)
// in       in         in_valid/in_stall   in_opcode, in_tap_index, in_value, in_last_sample
// out      out        out_valid/out_stall out_result_value, out_final_result
//
// a kernel write needs no scan; a sample push holds off input for a scan whose length is
// set by one full rotation of the cell ring past the single multiply-accumulate
// a last sample adds a tail result for each tap in use beyond the first
// after a tap count change the history ring realigns while input is stalled
// reset clears the history cells at once; the kernel holds garbage until written
// a stalled result holds the output register; the next scan runs meanwhile
module full_correlation_stream_unit #(
  parameter int MAX_TAPS    = fcs_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = fcs_pkg::ACC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fcs_pkg::TAP_COUNT_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [fcs_pkg::TAP_INDEX_W-1:0]     in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]       in_value,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ACC_BITS-1:0]          out_result_value,
  output logic                                out_final_result
);

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int NY_W  = $clog2(MAX_TAPS + 1);
  localparam int CW    = NY_W + fcs_pkg::TAP_COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [fcs_pkg::TAP_COUNT_W-1:0] tap_count_r;
  logic [IDX_W-1:0]            align_r, align_nxt;
  logic [IDX_W-1:0]            step_r, step_nxt;
  logic [IDX_W-1:0]            remain_r, remain_nxt;
  logic                        last_r, last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [ACC_BITS-1:0]  out_result_r;
  logic                        out_final_r;

  logic [CW-1:0]               tc_ext, ny, gap, tail, widx_full;
  logic [IDX_W-1:0]            align_target, widx;
  logic                        idx_ok, aligning, in_acc, out_free, done_load;
  logic                        tail_more, scan_end, use_tap;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [ACC_BITS-1:0]  total;
  fcs_pkg::fcs_cell_ctrl_t     ctrl;

  logic signed [SAMPLE_BITS-1:0] hist_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] kern_w [MAX_TAPS];

  // tap count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fcs_pkg::TAP_COUNT_W'(1);
    end else if (cfg_wr_en) begin
      tap_count_r <= cfg_wr_data;
    end
  end

  // taps in use, clamped to 1..MAX_TAPS
  assign tc_ext = CW'(tap_count_r);
  always_comb begin
    priority if (tc_ext == '0) begin
      ny = CW'(1);
    end else if (tc_ext > CW'(MAX_TAPS)) begin
      ny = CW'(MAX_TAPS);
    end else begin
      ny = tc_ext;
    end
  end

  // newest sample sits at cell MAX_TAPS - ny so cell c pairs with kernel MAX_TAPS-1-c
  assign gap          = CW'(MAX_TAPS) - ny;
  assign align_target = gap[IDX_W-1:0];
  assign tail         = ny - CW'(1);

  // kernel element k lives in cell MAX_TAPS-1-k
  assign widx_full = CW'(MAX_TAPS - 1) - CW'(in_tap_index);
  assign widx      = widx_full[IDX_W-1:0];
  assign idx_ok    = CW'(in_tap_index) < CW'(MAX_TAPS);

  // handshake
  assign aligning  = (state_r == ST_IDLE) && (align_r != align_target);
  assign in_stall  = (state_r != ST_IDLE) || (align_r != align_target);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign done_load = (state_r == ST_DONE) && out_free;
  assign tail_more = last_r && (remain_r != '0);
  assign scan_end  = step_r == IDX_W'(MAX_TAPS - 1);

  // the head cell holds original cell MAX_TAPS-1-step; count it while inside the window
  assign use_tap = ({1'b0, step_r} + {1'b0, align_r}) < (IDX_W + 1)'(MAX_TAPS);

  // cell commands
  always_comb begin
    ctrl.kern_write  = in_acc && (in_opcode == fcs_pkg::OP_KERNEL_WRITE) && idx_ok;
    ctrl.kern_shift  = state_r == ST_SCAN;
    ctrl.hist_shift  = aligning || (state_r == ST_SCAN);
    ctrl.hist_inject = (in_acc && (in_opcode == fcs_pkg::OP_SAMPLE_PUSH)) ||
                       (done_load && tail_more);
    ctrl.hist_clear  = done_load && last_r && (remain_r == '0);
  end

  // tail pushes shift in zeros
  assign sample_in = in_acc ? in_value : '0;

  // ring of cells, each taking from its lower neighbor
  for (genvar c = 0; c < MAX_TAPS; c++) begin : g_cell
    localparam int PREV = (c == 0) ? MAX_TAPS - 1 : c - 1;
    fcs_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (c)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .align_i    (align_r),
      .widx_i     (widx),
      .sample_i   (sample_in),
      .kdata_i    (in_value),
      .hist_prev_i(hist_w[PREV]),
      .kern_prev_i(kern_w[PREV]),
      .hist_o     (hist_w[c]),
      .kern_o     (kern_w[c])
    );
  end

  // multiply-accumulate at the head of the ring
  fcs_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_mac (
    .clk      (clk),
    .start_i  (ctrl.hist_inject),
    .step_i   (state_r == ST_SCAN),
    .use_tap_i(use_tap),
    .hist_i   (hist_w[MAX_TAPS-1]),
    .kern_i   (kern_w[MAX_TAPS-1]),
    .total_o  (total)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    remain_nxt = remain_r;
    last_nxt   = last_r;
    align_nxt  = align_r;
    unique case (state_r)
      ST_IDLE: begin
        if (aligning) begin
          align_nxt = (align_r == IDX_W'(MAX_TAPS - 1)) ? '0 : align_r + IDX_W'(1);
        end
        if (in_acc && (in_opcode == fcs_pkg::OP_SAMPLE_PUSH)) begin
          state_nxt  = ST_SCAN;
          step_nxt   = '0;
          last_nxt   = in_last_sample;
          remain_nxt = tail[IDX_W-1:0];
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (tail_more) begin
            state_nxt  = ST_SCAN;
            step_nxt   = '0;
            remain_nxt = remain_r - IDX_W'(1);
          end else begin
            state_nxt = ST_IDLE;
            last_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      align_r  <= IDX_W'(MAX_TAPS - 1);
      step_r   <= '0;
      remain_r <= '0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      align_r  <= align_nxt;
      step_r   <= step_nxt;
      remain_r <= remain_nxt;
      last_r   <= last_nxt;
    end
  end

  // output register
  always_comb begin
    priority if (done_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_result_r <= total;
      out_final_r  <= last_r && (remain_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_final_result = out_final_r;

endmodule

/* hdl/fcs_checker.sv */
`include "assert_macros.svh"

module fcs_checker #(
  parameter int ACC_BITS = fcs_pkg::ACC_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_opcode,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [ACC_BITS-1:0] out_result_value,
  input logic                       out_final_result
);

  logic in_acc;
  logic push_acc;
  logic out_held;
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_opcode == fcs_pkg::OP_SAMPLE_PUSH);
  assign out_held = out_valid && out_stall;

  // stalled result stays offered
  `FCS_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid, "out_valid dropped under stall")

  // stalled result payload holds
  `FCS_ASSERT(a_out_stable, clk, rst_n, out_held |=> $stable({out_result_value, out_final_result}), "out payload moved")

  // reset empties the output register
  `FCS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "out_valid set after reset")

  // no result appears in the cycle right after a transaction is taken
  `FCS_ASSERT(a_no_instant_result, clk, rst_n, in_acc |=> !$rose(out_valid), "result too early")

  // a sample push holds off the next transaction
  `FCS_ASSERT(a_push_busy, clk, rst_n, push_acc |=> in_stall, "input taken during scan")

endmodule

bind full_correlation_stream_unit fcs_checker #(
  .ACC_BITS(ACC_BITS)
) u_fcs_checker (.*);
